// ----- rtl/amsp_pkg.sv -----
package amsp_pkg;

  localparam int CharW   = 8;
  localparam int FlagW   = 16;
  localparam int StatusW = 13;
  localparam int DigitW  = 4;
  localparam int CountW  = 2;
  localparam int WinDepth = 3;

  localparam logic [CountW-1:0] WIN_FULL = CountW'(WinDepth);

  // flag bit positions in the accumulator
  localparam int FB_NOTRACK  = 0;   // n
  localparam int FB_NOGOTO   = 1;   // N
  localparam int FB_ATHOME   = 2;   // H
  localparam int FB_HOMING   = 3;   // h
  localparam int FB_AUTOHOME = 4;   // B
  localparam int FB_PPS      = 5;   // S
  localparam int FB_PULSE    = 6;   // G
  localparam int FB_GUIDE    = 7;   // g
  localparam int FB_WAITHOME = 8;   // w
  localparam int FB_PAUSE    = 9;   // u
  localparam int FB_BUZZER   = 10;  // z
  localparam int FB_MFLIP    = 11;  // a
  localparam int FB_PECREC   = 12;  // R
  localparam int FB_REFR     = 13;  // r
  localparam int FB_OTRK     = 14;  // t
  localparam int FB_SINGLE   = 15;  // s

  // tracking and goto report active unless their "off" letter was seen
  localparam logic [StatusW-1:0] STATUS_INV = StatusW'(3);

  localparam logic [2:0] COMP_NONE        = 3'd0;
  localparam logic [2:0] COMP_REFR_DUAL   = 3'd1;
  localparam logic [2:0] COMP_REFR_SINGLE = 3'd2;
  localparam logic [2:0] COMP_OTRK_DUAL   = 3'd3;
  localparam logic [2:0] COMP_OTRK_SINGLE = 3'd4;

  localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharW-1:0] DIGIT_MAX = 8'd9;

  typedef struct packed {
    logic [FlagW-1:0] flags;
    logic             park_hit;
    logic [1:0]       park;
    logic             rate_hit;
    logic [1:0]       rate;
    logic             pec_hit;
    logic [2:0]       pec;
    logic             mount_hit;
    logic [1:0]       mount;
    logic             pier_hit;
    logic [1:0]       pier;
  } flag_dec_t;

  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_ZERO + DIGIT_MAX) begin
      d = DigitW'(c - CH_ZERO);
    end
    return d;
  endfunction

endpackage

// ----- rtl/amsp_chan_if.sv -----
interface amsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [amsp_pkg::CharW-1:0]  ch;
  logic                        last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface amsp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          valid_res;
  logic [amsp_pkg::StatusW-1:0]  status_bits;
  logic [1:0]                    park_state;
  logic [1:0]                    track_rate;
  logic [2:0]                    track_comp;
  logic [1:0]                    pier_side;
  logic [1:0]                    mount_type;
  logic [2:0]                    pec_state;
  logic [amsp_pkg::DigitW-1:0]   pulse_guide_rate;
  logic [amsp_pkg::DigitW-1:0]   guide_rate;
  logic [amsp_pkg::DigitW-1:0]   error_code;

  modport source (output valid, output valid_res, output status_bits, output park_state,
                  output track_rate, output track_comp, output pier_side,
                  output mount_type, output pec_state, output pulse_guide_rate,
                  output guide_rate, output error_code, input ready);
  modport sink   (input valid, input valid_res, input status_bits, input park_state,
                  input track_rate, input track_comp, input pier_side,
                  input mount_type, input pec_state, input pulse_guide_rate,
                  input guide_rate, input error_code, output ready);
endinterface

// ----- rtl/amsp_flag_decode.sv -----
module amsp_flag_decode (
  input  logic [amsp_pkg::CharW-1:0] ch,
  output amsp_pkg::flag_dec_t        dec
);

  always_comb begin
    dec = '0;
    case (ch)
      "n": dec.flags[amsp_pkg::FB_NOTRACK]  = 1'b1;
      "N": dec.flags[amsp_pkg::FB_NOGOTO]   = 1'b1;
      "H": dec.flags[amsp_pkg::FB_ATHOME]   = 1'b1;
      "h": dec.flags[amsp_pkg::FB_HOMING]   = 1'b1;
      "B": dec.flags[amsp_pkg::FB_AUTOHOME] = 1'b1;
      "S": dec.flags[amsp_pkg::FB_PPS]      = 1'b1;
      "G": dec.flags[amsp_pkg::FB_PULSE]    = 1'b1;
      "g": dec.flags[amsp_pkg::FB_GUIDE]    = 1'b1;
      "w": dec.flags[amsp_pkg::FB_WAITHOME] = 1'b1;
      "u": dec.flags[amsp_pkg::FB_PAUSE]    = 1'b1;
      "z": dec.flags[amsp_pkg::FB_BUZZER]   = 1'b1;
      "a": dec.flags[amsp_pkg::FB_MFLIP]    = 1'b1;
      "R": dec.flags[amsp_pkg::FB_PECREC]   = 1'b1;
      "r": dec.flags[amsp_pkg::FB_REFR]     = 1'b1;
      "t": dec.flags[amsp_pkg::FB_OTRK]     = 1'b1;
      "s": dec.flags[amsp_pkg::FB_SINGLE]   = 1'b1;
      "p": begin dec.park_hit = 1'b1; dec.park = 2'd0; end
      "I": begin dec.park_hit = 1'b1; dec.park = 2'd1; end
      "P": begin dec.park_hit = 1'b1; dec.park = 2'd2; end
      "F": begin dec.park_hit = 1'b1; dec.park = 2'd3; end
      "(": begin dec.rate_hit = 1'b1; dec.rate = 2'd1; end
      "O": begin dec.rate_hit = 1'b1; dec.rate = 2'd2; end
      "k": begin dec.rate_hit = 1'b1; dec.rate = 2'd3; end
      "/": begin dec.pec_hit = 1'b1; dec.pec = 3'd0; end
      ",": begin dec.pec_hit = 1'b1; dec.pec = 3'd1; end
      "~": begin dec.pec_hit = 1'b1; dec.pec = 3'd2; end
      ";": begin dec.pec_hit = 1'b1; dec.pec = 3'd3; end
      "^": begin dec.pec_hit = 1'b1; dec.pec = 3'd4; end
      "E": begin dec.mount_hit = 1'b1; dec.mount = 2'd0; end
      "K": begin dec.mount_hit = 1'b1; dec.mount = 2'd1; end
      "A": begin dec.mount_hit = 1'b1; dec.mount = 2'd2; end
      "L": begin dec.mount_hit = 1'b1; dec.mount = 2'd3; end
      "o": begin dec.pier_hit = 1'b1; dec.pier = 2'd0; end
      "T": begin dec.pier_hit = 1'b1; dec.pier = 2'd1; end
      "W": begin dec.pier_hit = 1'b1; dec.pier = 2'd2; end
      default: dec = '0;
    endcase
  end

endmodule

// ----- rtl/ascii_mount_status_parser.sv -----
// output: the status record is registered when the final character is accepted and is valid in the following cycle
// throughput: one character per cycle; non-final characters are taken even while a
// record waits at the output, a final character waits only for the output register
// reset: synchronous, active low; clears the character count, flag and code state
// and the output valid; the character window needs no reset
module ascii_mount_status_parser (
  input  logic            clk,
  input  logic            rst_n,
  amsp_in_if.sink         in_chan,
  amsp_out_if.source      out_chan
);

  logic [amsp_pkg::CharW-1:0]  win_r [amsp_pkg::WinDepth];
  logic [amsp_pkg::CharW-1:0]  win_nxt [amsp_pkg::WinDepth];
  logic [amsp_pkg::CountW-1:0] cnt_r, cnt_nxt;
  logic [amsp_pkg::FlagW-1:0]  flags_r, flags_nxt;
  logic [1:0]                  park_r, park_nxt;
  logic [1:0]                  rate_r, rate_nxt;
  logic [2:0]                  pec_r, pec_nxt;
  logic [1:0]                  mount_r, mount_nxt;
  logic [1:0]                  pier_r, pier_nxt;

  logic                          out_valid_r;
  logic                          res_valid_r, res_valid_nxt;
  logic [amsp_pkg::StatusW-1:0]  status_r, status_nxt;
  logic [1:0]                    park_out_r, rate_out_r, pier_out_r, mount_out_r;
  logic [2:0]                    comp_out_r, pec_out_r, comp_nxt;
  logic [amsp_pkg::DigitW-1:0]   dig0_r, dig1_r, dig2_r;

  amsp_pkg::flag_dec_t dec;
  logic                do_dec;
  logic                accept;
  logic                out_free;

  amsp_flag_decode u_dec (
    .ch  (win_r[0]),
    .dec (dec)
  );

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = out_free || !in_chan.last;
  assign accept        = in_chan.valid && in_chan.ready;
  assign do_dec        = (cnt_r == amsp_pkg::WIN_FULL);

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = in_chan.ch;
    cnt_nxt    = (cnt_r == amsp_pkg::WIN_FULL) ? cnt_r : cnt_r + 1'b1;
    flags_nxt  = do_dec ? (flags_r | dec.flags) : flags_r;
    park_nxt   = (do_dec && dec.park_hit)  ? dec.park  : park_r;
    rate_nxt   = (do_dec && dec.rate_hit)  ? dec.rate  : rate_r;
    pec_nxt    = (do_dec && dec.pec_hit)   ? dec.pec   : pec_r;
    mount_nxt  = (do_dec && dec.mount_hit) ? dec.mount : mount_r;
    pier_nxt   = (do_dec && dec.pier_hit)  ? dec.pier  : pier_r;

    res_valid_nxt = (cnt_nxt == amsp_pkg::WIN_FULL);
    status_nxt    = flags_nxt[amsp_pkg::StatusW-1:0] ^ amsp_pkg::STATUS_INV;
    if (flags_nxt[amsp_pkg::FB_REFR]) begin
      comp_nxt = flags_nxt[amsp_pkg::FB_SINGLE] ? amsp_pkg::COMP_REFR_SINGLE
                                                : amsp_pkg::COMP_REFR_DUAL;
    end else if (flags_nxt[amsp_pkg::FB_OTRK]) begin
      comp_nxt = flags_nxt[amsp_pkg::FB_SINGLE] ? amsp_pkg::COMP_OTRK_SINGLE
                                                : amsp_pkg::COMP_OTRK_DUAL;
    end else begin
      comp_nxt = amsp_pkg::COMP_NONE;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flags_r <= '0;
      park_r  <= '0;
      rate_r  <= '0;
      pec_r   <= '0;
      mount_r <= '0;
      pier_r  <= '0;
    end else if (accept) begin
      if (in_chan.last) begin
        cnt_r   <= '0;
        flags_r <= '0;
        park_r  <= '0;
        rate_r  <= '0;
        pec_r   <= '0;
        mount_r <= '0;
        pier_r  <= '0;
      end else begin
        cnt_r   <= cnt_nxt;
        flags_r <= flags_nxt;
        park_r  <= park_nxt;
        rate_r  <= rate_nxt;
        pec_r   <= pec_nxt;
        mount_r <= mount_nxt;
        pier_r  <= pier_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_chan.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.last) begin
      res_valid_r <= res_valid_nxt;
      if (res_valid_nxt) begin
        status_r    <= status_nxt;
        park_out_r  <= park_nxt;
        rate_out_r  <= rate_nxt;
        comp_out_r  <= comp_nxt;
        pier_out_r  <= pier_nxt;
        mount_out_r <= mount_nxt;
        pec_out_r   <= pec_nxt;
        dig0_r      <= amsp_pkg::digit_of(win_nxt[0]);
        dig1_r      <= amsp_pkg::digit_of(win_nxt[1]);
        dig2_r      <= amsp_pkg::digit_of(win_nxt[2]);
      end else begin
        status_r    <= '0;
        park_out_r  <= '0;
        rate_out_r  <= '0;
        comp_out_r  <= '0;
        pier_out_r  <= '0;
        mount_out_r <= '0;
        pec_out_r   <= '0;
        dig0_r      <= '0;
        dig1_r      <= '0;
        dig2_r      <= '0;
      end
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.valid_res        = res_valid_r;
  assign out_chan.status_bits      = status_r;
  assign out_chan.park_state       = park_out_r;
  assign out_chan.track_rate       = rate_out_r;
  assign out_chan.track_comp       = comp_out_r;
  assign out_chan.pier_side        = pier_out_r;
  assign out_chan.mount_type       = mount_out_r;
  assign out_chan.pec_state        = pec_out_r;
  assign out_chan.pulse_guide_rate = dig0_r;
  assign out_chan.guide_rate       = dig1_r;
  assign out_chan.error_code       = dig2_r;

endmodule

// ----- tb/amsp_status_checker.sv -----
`timescale 1ns / 100ps

module amsp_status_checker
  import amsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  amsp_in_if   in_mon,
  amsp_out_if  out_mon,
  output int   errors,
  output int   pending
);

  localparam logic [1:0] PARK_UNPARKED = 2'd0;
  localparam logic [1:0] PARK_PARKING  = 2'd1;
  localparam logic [1:0] PARK_PARKED   = 2'd2;
  localparam logic [1:0] PARK_FAILED   = 2'd3;

  localparam logic [1:0] RATE_LUNAR = 2'd1;
  localparam logic [1:0] RATE_SOLAR = 2'd2;
  localparam logic [1:0] RATE_KING  = 2'd3;

  localparam logic [2:0] PEC_IGNORE       = 3'd0;
  localparam logic [2:0] PEC_READY_PLAY   = 3'd1;
  localparam logic [2:0] PEC_PLAYING      = 3'd2;
  localparam logic [2:0] PEC_READY_RECORD = 3'd3;
  localparam logic [2:0] PEC_RECORDING    = 3'd4;

  localparam logic [1:0] MOUNT_GEM    = 2'd0;
  localparam logic [1:0] MOUNT_FORK   = 2'd1;
  localparam logic [1:0] MOUNT_ALTAZ  = 2'd2;
  localparam logic [1:0] MOUNT_ALTALT = 2'd3;

  localparam logic [1:0] PIER_NONE = 2'd0;
  localparam logic [1:0] PIER_EAST = 2'd1;
  localparam logic [1:0] PIER_WEST = 2'd2;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic               valid_res;
    logic [StatusW-1:0] status_bits;
    logic [1:0]         park_state;
    logic [1:0]         track_rate;
    logic [2:0]         track_comp;
    logic [1:0]         pier_side;
    logic [1:0]         mount_type;
    logic [2:0]         pec_state;
    logic [DigitW-1:0]  pulse_guide_rate;
    logic [DigitW-1:0]  guide_rate;
    logic [DigitW-1:0]  error_code;
  } status_rec_t;

  status_rec_t       status_q[$];
  logic [CharW-1:0]  held_chars[WinDepth];
  logic [CountW-1:0] held_count;
  logic [FlagW-1:0]  flag_bits;
  logic [1:0]        park_now;
  logic [1:0]        rate_now;
  logic [2:0]        pec_now;
  logic [1:0]        mount_now;
  logic [1:0]        pier_now;
  int                mismatches = 0;
  int                waiting = 0;

  assign errors  = mismatches;
  assign pending = waiting;

  function automatic logic [DigitW-1:0] char_digit(input logic [CharW-1:0] c);
    if (c < "0" || c > "9") return '0;
    return DigitW'(c - "0");
  endfunction

  task automatic clear_reply();
    foreach (held_chars[i]) held_chars[i] = '0;
    held_count = '0;
    flag_bits  = '0;
    park_now   = PARK_UNPARKED;
    rate_now   = '0;
    pec_now    = PEC_IGNORE;
    mount_now  = MOUNT_GEM;
    pier_now   = PIER_NONE;
  endtask

  task automatic decode_status_char(input logic [CharW-1:0] c);
    case (c)
      "n": flag_bits[FB_NOTRACK]  = 1'b1;
      "N": flag_bits[FB_NOGOTO]   = 1'b1;
      "H": flag_bits[FB_ATHOME]   = 1'b1;
      "h": flag_bits[FB_HOMING]   = 1'b1;
      "B": flag_bits[FB_AUTOHOME] = 1'b1;
      "S": flag_bits[FB_PPS]      = 1'b1;
      "G": flag_bits[FB_PULSE]    = 1'b1;
      "g": flag_bits[FB_GUIDE]    = 1'b1;
      "w": flag_bits[FB_WAITHOME] = 1'b1;
      "u": flag_bits[FB_PAUSE]    = 1'b1;
      "z": flag_bits[FB_BUZZER]   = 1'b1;
      "a": flag_bits[FB_MFLIP]    = 1'b1;
      "R": flag_bits[FB_PECREC]   = 1'b1;
      "r": flag_bits[FB_REFR]     = 1'b1;
      "t": flag_bits[FB_OTRK]     = 1'b1;
      "s": flag_bits[FB_SINGLE]   = 1'b1;
      "p": park_now  = PARK_UNPARKED;
      "I": park_now  = PARK_PARKING;
      "P": park_now  = PARK_PARKED;
      "F": park_now  = PARK_FAILED;
      "(": rate_now  = RATE_LUNAR;
      "O": rate_now  = RATE_SOLAR;
      "k": rate_now  = RATE_KING;
      "/": pec_now   = PEC_IGNORE;
      ",": pec_now   = PEC_READY_PLAY;
      "~": pec_now   = PEC_PLAYING;
      ";": pec_now   = PEC_READY_RECORD;
      "^": pec_now   = PEC_RECORDING;
      "E": mount_now = MOUNT_GEM;
      "K": mount_now = MOUNT_FORK;
      "A": mount_now = MOUNT_ALTAZ;
      "L": mount_now = MOUNT_ALTALT;
      "o": pier_now  = PIER_NONE;
      "T": pier_now  = PIER_EAST;
      "W": pier_now  = PIER_WEST;
      default: ;
    endcase
  endtask

  task automatic take_char(input logic [CharW-1:0] c, input logic fin);
    status_rec_t rec;
    logic        single;
    if (held_count == WIN_FULL) decode_status_char(held_chars[0]);
    held_chars[0] = held_chars[1];
    held_chars[1] = held_chars[2];
    held_chars[2] = c;
    if (held_count != WIN_FULL) held_count = held_count + 1'b1;
    if (fin) begin
      rec = '0;
      if (held_count == WIN_FULL) begin
        single                = flag_bits[FB_SINGLE];
        rec.valid_res         = 1'b1;
        rec.status_bits       = flag_bits[StatusW-1:0] ^ STATUS_INV;
        rec.park_state        = park_now;
        rec.track_rate        = rate_now;
        rec.pier_side         = pier_now;
        rec.mount_type        = mount_now;
        rec.pec_state         = pec_now;
        rec.pulse_guide_rate  = char_digit(held_chars[0]);
        rec.guide_rate        = char_digit(held_chars[1]);
        rec.error_code        = char_digit(held_chars[2]);
        // refraction wins over the other compensation letter
        if (flag_bits[FB_REFR]) begin
          rec.track_comp = single ? COMP_REFR_SINGLE : COMP_REFR_DUAL;
        end else if (flag_bits[FB_OTRK]) begin
          rec.track_comp = single ? COMP_OTRK_SINGLE : COMP_OTRK_DUAL;
        end else begin
          rec.track_comp = COMP_NONE;
        end
      end
      status_q.push_back(rec);
      clear_reply();
    end
  endtask

  always @(posedge clk) begin
    status_rec_t got;
    status_rec_t want;
    if (!rst_n) begin
      clear_reply();
      status_q.delete();
    end else begin
      // results first so a record never matches a transaction from the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.valid_res        = out_mon.valid_res;
        got.status_bits      = out_mon.status_bits;
        got.park_state       = out_mon.park_state;
        got.track_rate       = out_mon.track_rate;
        got.track_comp       = out_mon.track_comp;
        got.pier_side        = out_mon.pier_side;
        got.mount_type       = out_mon.mount_type;
        got.pec_state        = out_mon.pec_state;
        got.pulse_guide_rate = out_mon.pulse_guide_rate;
        got.guide_rate       = out_mon.guide_rate;
        got.error_code       = out_mon.error_code;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) $display("unexpected status record: %p", got);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("status mismatch: expected %p", want);
              $display("                 actual   %p", got);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) take_char(in_mon.ch, in_mon.last);
    end
    waiting = status_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import amsp_pkg::*;

  typedef logic [CharW-1:0] reply_t[$];

  localparam int TARGET_CHARS = 500;
  localparam int IDLE_PCT     = 11;
  localparam string STATUS_LETTERS = "nNHhBSGgwuzaRrtspIPF(Ok/,~;^EKALoTW";

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle = 1'b0;
  int   errors;
  int   pending;

  amsp_in_if  in_if ();
  amsp_out_if out_if ();

  ascii_mount_status_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  amsp_status_checker checker_i (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_if),
    .out_mon (out_if),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_char(input logic [CharW-1:0] c, input logic fin);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= fin;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_reply(input reply_t r);
    foreach (r[i]) send_char(r[i], i == r.size() - 1);
  endtask

  function automatic logic [CharW-1:0] any_char();
    return CharW'($urandom_range(255));
  endfunction

  function automatic logic [CharW-1:0] status_letter();
    return STATUS_LETTERS[$urandom_range(STATUS_LETTERS.len() - 1)];
  endfunction

  initial begin
    reply_t reply;
    int     sent;
    int     kind;
    int     n;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.ch     = '0;
    in_if.last   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short replies, r over t with single axis, digit boundaries and byte extremes
    reply = '{"5"};
    send_reply(reply);
    reply = '{"a", "b"};
    send_reply(reply);
    reply = '{"r", "t", "s", "1", "2", "3"};
    send_reply(reply);
    reply = '{"n", "N", 8'h00, 8'hFF, "9"};
    send_reply(reply);
    reply = '{"t", "P", "k", "W", "/", "9", ":"};
    send_reply(reply);
    reply = '{"0", "1", "2"};
    send_reply(reply);

    sent = 0;
    while (sent < TARGET_CHARS) begin
      no_idle = (sent >= 200 && sent < 320);
      reply.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
        n = $urandom_range(1, 2);
        repeat (n) reply.push_back(any_char());
      end else if (kind < 16) begin
        n = $urandom_range(3, 10);
        repeat (n) reply.push_back(any_char());
      end else begin
        n = $urandom_range(0, 10);
        repeat (n) reply.push_back(($urandom_range(9) == 0) ? any_char() : status_letter());
        repeat (3) begin
          if ($urandom_range(99) < 85) reply.push_back("0" + CharW'($urandom_range(9)));
          else reply.push_back(any_char());
        end
      end
      send_reply(reply);
      sent += reply.size();
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
